// ===== hw/rtl/etmr_pkg.sv =====
package etmr_pkg;

    // Current moment as carried by one input transaction
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_in_item;

    // Elapsed time as carried by one output transaction
    typedef struct packed {
        logic       before_start;
        logic [6:0] elapsed_years;
        logic [3:0] elapsed_months;
        logic [4:0] elapsed_days;
        logic [4:0] elapsed_hours;
        logic [5:0] elapsed_minutes;
        logic [5:0] elapsed_seconds;
    } t_out_item;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MONTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd5;

    // Saturation values once more than 127 whole years have gone by
    localparam logic [6:0] SAT_YEARS   = 7'd127;
    localparam logic [3:0] SAT_MONTHS  = 4'd11;
    localparam logic [4:0] SAT_DAYS    = 5'd29;
    localparam logic [4:0] SAT_HOURS   = 5'd23;
    localparam logic [5:0] SAT_MINUTES = 6'd59;
    localparam logic [5:0] SAT_SECONDS = 6'd59;

endpackage

// ===== hw/rtl/etmr_in_if.sv =====
interface etmr_in_if
    import etmr_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/etmr_out_if.sv =====
interface etmr_out_if
    import etmr_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/elapsed_time_mixed_radix.sv =====
// Channel    Dir  Handshake        Payload
// ---------  ---  ---------------  -----------------------------------------------
// i_req      in   valid / ready    year, month, day_of_month, hour, minute, second
// o_rsp      out  valid / ready    before_start, elapsed_years .. elapsed_seconds
// i_cfg_*    in   write enable     start moment registers, index 0..5
//
// Seven register stages, one transaction per clock when o_rsp is not stalled.
// The depth is set by the chain of constant-reciprocal multiplies and
// remainder subtracts. Reset (i_rst_n low, synchronous) empties the pipeline
// and loads the start registers with 2018-05-02 12:30:00. A stall at o_rsp
// backs up stage by stage; empty stages keep filling, and i_req.ready drops
// only once the pipe is full.
//
// Method: each moment becomes a day number (counted from March 1 of the year
// before 2000, so leap days fall at the end of a counting year) plus a
// second-of-day value. The two differences are normalized into whole days and
// seconds below one day; days then split by 360 and 30, seconds by 3600 and 60.
module elapsed_time_mixed_radix
    import etmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    etmr_in_if.sink               i_req,
    etmr_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTG = 7;

    typedef struct packed {
        logic [15:0] day_num;
        logic [16:0] tod;
    } t_moment;

    // Days from the start of the counting year (March 1) to the first of the
    // given month. Month 0 is the December before, months 13..15 run on.
    function automatic logic [8:0] month_doy(input logic [3:0] mo);
        logic [8:0] d;
        unique case (mo)
            4'd0, 4'd12: d = 9'd275;
            4'd1, 4'd13: d = 9'd306;
            4'd2, 4'd14: d = 9'd337;
            4'd3, 4'd15: d = 9'd0;
            4'd4:        d = 9'd31;
            4'd5:        d = 9'd61;
            4'd6:        d = 9'd92;
            4'd7:        d = 9'd122;
            4'd8:        d = 9'd153;
            4'd9:        d = 9'd184;
            4'd10:       d = 9'd214;
            default:     d = 9'd245;
        endcase
        return d;
    endfunction

    // Counting-year offset relative to the year field
    function automatic logic [1:0] month_yofs(input logic [3:0] mo);
        logic [1:0] o;
        unique case (mo)
            4'd0, 4'd1, 4'd2: o = 2'd0;
            4'd15:            o = 2'd2;
            default:          o = 2'd1;
        endcase
        return o;
    endfunction

    function automatic t_moment moment_of(
        input logic [6:0] yr, input logic [3:0] mo, input logic [4:0] dd,
        input logic [4:0] hh, input logic [5:0] mi, input logic [5:0] ss);
        t_moment    m;
        logic [7:0] q;
        logic [8:0] q3;
        logic [6:0] leaps;
        logic       no_leap_2100;
        q            = {1'b0, yr} + {6'd0, month_yofs(mo)};
        q3           = {1'b0, q} + 9'd3;
        leaps        = q3[8:2];
        no_leap_2100 = (q >= 8'd101);
        m.day_num    = {8'd0, q} * 16'd365 + {9'd0, leaps} - {15'd0, no_leap_2100}
                     + {7'd0, month_doy(mo)} + {11'd0, dd};
        m.tod        = {12'd0, hh} * 17'd3600 + {11'd0, mi} * 17'd60 + {11'd0, ss};
        return m;
    endfunction

    // ---------------- configuration ----------------
    logic [6:0] r_start_year;
    logic [3:0] r_start_month;
    logic [4:0] r_start_day;
    logic [4:0] r_start_hour;
    logic [5:0] r_start_minute;
    logic [5:0] r_start_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_year   <= 7'd18;
            r_start_month  <= 4'd5;
            r_start_day    <= 5'd2;
            r_start_hour   <= 5'd12;
            r_start_minute <= 6'd30;
            r_start_second <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_YEAR:   r_start_year   <= i_cfg_data;
                CFG_START_MONTH:  r_start_month  <= i_cfg_data[3:0];
                CFG_START_DAY:    r_start_day    <= i_cfg_data[4:0];
                CFG_START_HOUR:   r_start_hour   <= i_cfg_data[4:0];
                CFG_START_MINUTE: r_start_minute <= i_cfg_data[5:0];
                CFG_START_SECOND: r_start_second <= i_cfg_data[5:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or its contents move on this cycle.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || o_rsp.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = adv[0];

    // ---------------- stage 1: day number and second of day ----------------
    t_moment r_s1_now;
    t_moment r_s1_sta;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_now <= moment_of(i_req.data.year, i_req.data.month, i_req.data.day_of_month,
                                  i_req.data.hour, i_req.data.minute, i_req.data.second);
            r_s1_sta <= moment_of(r_start_year, r_start_month, r_start_day,
                                  r_start_hour, r_start_minute, r_start_second);
        end
    end

    // ---------------- stage 2: raw differences ----------------
    logic signed [16:0] r_s2_dd;
    logic signed [18:0] r_s2_dt;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_dd <= signed'({1'b0, r_s1_now.day_num} - {1'b0, r_s1_sta.day_num});
            r_s2_dt <= signed'({2'b0, r_s1_now.tod} - {2'b0, r_s1_sta.tod});
        end
    end

    // ---------------- stage 3: borrow/carry between days and seconds ----------------
    logic signed [16:0] n_s3_dd;
    logic signed [18:0] n_s3_dt;
    logic               r_s3_neg;
    logic [15:0]        r_s3_days;
    logic [16:0]        r_s3_tod;

    always_comb begin
        priority if (r_s2_dt < -19'sd86400) begin
            n_s3_dt = r_s2_dt + 19'sd172800;
            n_s3_dd = r_s2_dd - 17'sd2;
        end else if (r_s2_dt < 19'sd0) begin
            n_s3_dt = r_s2_dt + 19'sd86400;
            n_s3_dd = r_s2_dd - 17'sd1;
        end else if (r_s2_dt >= 19'sd86400) begin
            n_s3_dt = r_s2_dt - 19'sd86400;
            n_s3_dd = r_s2_dd + 17'sd1;
        end else begin
            n_s3_dt = r_s2_dt;
            n_s3_dd = r_s2_dd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_neg  <= n_s3_dd[16];
            r_s3_days <= n_s3_dd[15:0];
            r_s3_tod  <= n_s3_dt[16:0];
        end
    end

    // ---------------- stage 4: years = days/360, hours = tod/3600 ----------------
    logic [29:0] n_s4_yprod;
    logic [33:0] n_s4_hprod;
    logic        r_s4_neg;
    logic        r_s4_sat;
    logic [7:0]  r_s4_yrs;
    logic [4:0]  r_s4_hrs;
    logic [15:0] r_s4_days;
    logic [16:0] r_s4_tod;

    assign n_s4_yprod = {14'd0, r_s3_days} * 30'd11651;  // 2^22/360 rounded up
    assign n_s4_hprod = {17'd0, r_s3_tod} * 34'd74566;   // 2^28/3600 rounded up

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_neg  <= r_s3_neg;
            r_s4_sat  <= (r_s3_days >= 16'd46080);  // 128 years of 360 days
            r_s4_yrs  <= n_s4_yprod[29:22];
            r_s4_hrs  <= n_s4_hprod[32:28];
            r_s4_days <= r_s3_days;
            r_s4_tod  <= r_s3_tod;
        end
    end

    // ---------------- stage 5: remainders ----------------
    logic [15:0] n_s5_ry;
    logic [16:0] n_s5_rh;
    logic        r_s5_neg;
    logic        r_s5_sat;
    logic [6:0]  r_s5_yrs;
    logic [4:0]  r_s5_hrs;
    logic [8:0]  r_s5_rem_y;
    logic [11:0] r_s5_rem_h;

    assign n_s5_ry = r_s4_days - {8'd0, r_s4_yrs} * 16'd360;
    assign n_s5_rh = r_s4_tod - {12'd0, r_s4_hrs} * 17'd3600;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_neg   <= r_s4_neg;
            r_s5_sat   <= r_s4_sat;
            r_s5_yrs   <= r_s4_yrs[6:0];
            r_s5_hrs   <= r_s4_hrs;
            r_s5_rem_y <= n_s5_ry[8:0];
            r_s5_rem_h <= n_s5_rh[11:0];
        end
    end

    // ---------------- stage 6: months = rem/30, minutes = rem/60 ----------------
    logic [18:0] n_s6_mprod;
    logic [24:0] n_s6_iprod;
    logic        r_s6_neg;
    logic        r_s6_sat;
    logic [6:0]  r_s6_yrs;
    logic [4:0]  r_s6_hrs;
    logic [3:0]  r_s6_mos;
    logic [5:0]  r_s6_mins;
    logic [8:0]  r_s6_rem_y;
    logic [11:0] r_s6_rem_h;

    assign n_s6_mprod = {10'd0, r_s5_rem_y} * 19'd547;   // 2^14/30 rounded up
    assign n_s6_iprod = {13'd0, r_s5_rem_h} * 25'd4370;  // 2^18/60 rounded up

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s6_neg   <= r_s5_neg;
            r_s6_sat   <= r_s5_sat;
            r_s6_yrs   <= r_s5_yrs;
            r_s6_hrs   <= r_s5_hrs;
            r_s6_mos   <= n_s6_mprod[17:14];
            r_s6_mins  <= n_s6_iprod[23:18];
            r_s6_rem_y <= r_s5_rem_y;
            r_s6_rem_h <= r_s5_rem_h;
        end
    end

    // ---------------- stage 7: last remainders, output register ----------------
    logic [8:0]  n_s7_day;
    logic [11:0] n_s7_sec;
    t_out_item   n_out;
    t_out_item   r_out;

    assign n_s7_day = r_s6_rem_y - {5'd0, r_s6_mos} * 9'd30;
    assign n_s7_sec = r_s6_rem_h - {6'd0, r_s6_mins} * 12'd60;

    always_comb begin
        priority if (r_s6_neg) begin
            n_out              = '0;
            n_out.before_start = 1'b1;
        end else if (r_s6_sat) begin
            n_out.before_start    = 1'b0;
            n_out.elapsed_years   = SAT_YEARS;
            n_out.elapsed_months  = SAT_MONTHS;
            n_out.elapsed_days    = SAT_DAYS;
            n_out.elapsed_hours   = SAT_HOURS;
            n_out.elapsed_minutes = SAT_MINUTES;
            n_out.elapsed_seconds = SAT_SECONDS;
        end else begin
            n_out.before_start    = 1'b0;
            n_out.elapsed_years   = r_s6_yrs;
            n_out.elapsed_months  = r_s6_mos;
            n_out.elapsed_days    = n_s7_day[4:0];
            n_out.elapsed_hours   = r_s6_hrs;
            n_out.elapsed_minutes = r_s6_mins;
            n_out.elapsed_seconds = n_s7_sec[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_vld[NSTG-1];
    assign o_rsp.data  = r_out;

endmodule

// ===== hw/rtl/etmr_chk.sv =====
module etmr_chk
    import etmr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_rsp_valid,
    input logic      i_rsp_ready,
    input t_out_item i_rsp_data
);

    // A stalled result transaction stays put
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result changed while stalled");

    // Synchronous reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // Before the start moment every count reads zero
    a_before_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.before_start |->
            i_rsp_data.elapsed_years == 7'd0 && i_rsp_data.elapsed_months == 4'd0 &&
            i_rsp_data.elapsed_days == 5'd0 && i_rsp_data.elapsed_hours == 5'd0 &&
            i_rsp_data.elapsed_minutes == 6'd0 && i_rsp_data.elapsed_seconds == 6'd0)
        else $error("nonzero count with before_start");

    // Mixed-radix digits stay below their radix
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            i_rsp_data.elapsed_months <= SAT_MONTHS && i_rsp_data.elapsed_days <= SAT_DAYS &&
            i_rsp_data.elapsed_hours <= SAT_HOURS && i_rsp_data.elapsed_minutes <= SAT_MINUTES &&
            i_rsp_data.elapsed_seconds <= SAT_SECONDS)
        else $error("elapsed digit out of range");

endmodule

bind elapsed_time_mixed_radix etmr_chk u_etmr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
